// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, constants and helpers of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Parser phases, one per part of a frame
    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_SIZE    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_wsd_phase;

    // Frame opcodes
    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    // Reported frame types
    localparam logic [2:0] TYPE_TEXT   = 3'd0;
    localparam logic [2:0] TYPE_BINARY = 3'd1;
    localparam logic [2:0] TYPE_PING   = 3'd2;
    localparam logic [2:0] TYPE_PONG   = 3'd3;
    localparam logic [2:0] TYPE_CLOSE  = 3'd4;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Number of extended length bytes and mask key bytes
    localparam logic [3:0] HDR_EXT16 = 4'd2;
    localparam logic [3:0] HDR_EXT64 = 4'd8;
    localparam logic [3:0] HDR_MASK  = 4'd4;

    // One result item
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        message_start;
        logic        frame_done;
        logic [2:0]  frame_type;
        logic [15:0] close_code;
    } t_wsd_result;

    // True for the opcodes whose final frame is reported
    function automatic logic known_opcode(input logic [3:0] opc);
        logic known;
        case (opc)
            OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG: known = 1'b1;
            default:                                             known = 1'b0;
        endcase
        return known;
    endfunction

    // Maps an opcode to the reported frame type
    function automatic logic [2:0] opcode_type(input logic [3:0] opc);
        logic [2:0] ft;
        case (opc)
            OPC_TEXT:   ft = TYPE_TEXT;
            OPC_BINARY: ft = TYPE_BINARY;
            OPC_PING:   ft = TYPE_PING;
            OPC_PONG:   ft = TYPE_PONG;
            OPC_CLOSE:  ft = TYPE_CLOSE;
            default:    ft = TYPE_TEXT;
        endcase
        return ft;
    endfunction

endpackage

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame parser: takes one byte per transfer, updates the header and payload
// state and forms the result item that the byte causes, if any.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,     // byte accepted this cycle
    input  logic [7:0]  i_byte,
    output logic        o_res_valid, // a result item is formed this cycle
    output t_wsd_result o_res
);

    // State registers
    t_wsd_phase  r_phase,    n_phase;
    logic        r_final,    n_final;
    logic [3:0]  r_opcode,   n_opcode;
    logic        r_masked,   n_masked;
    logic [63:0] r_len,      n_len;
    logic [3:0]  r_hdr,      n_hdr;
    logic [7:0]  r_key [4];
    logic [7:0]  n_key [4];
    logic [1:0]  r_mask_idx, n_mask_idx;
    logic [1:0]  r_cnt,      n_cnt;
    logic [15:0] r_ftb,      n_ftb;
    logic        r_start,    n_start;

    // Decode signals
    logic [6:0]  w_len7;
    logic        w_ext;
    logic [3:0]  w_hdr_dec;
    logic        w_hdr_last;
    logic        w_chk;
    logic        w_chk_masked;
    logic [63:0] w_new_len;
    logic        w_end;
    logic        w_to_mask;
    logic        w_to_pay;
    logic [1:0]  w_key_idx;
    logic [7:0]  w_pb;
    logic        w_done;

    // Decode of the current byte against the phase
    always_comb begin
        w_len7     = i_byte[6:0];
        w_ext      = (w_len7 == LEN_EXT16) || (w_len7 == LEN_EXT64);
        w_hdr_dec  = r_hdr - 4'd1;
        w_hdr_last = (w_hdr_dec == 4'd0);
        w_key_idx  = 2'(HDR_MASK - r_hdr);
        w_pb       = i_byte ^ r_key[r_mask_idx];

        // The length (or, in the mask phase, the mask key) is complete and the next part of the frame is chosen
        w_chk = ((r_phase == PH_SIZE) && !w_ext) ||
                ((r_phase == PH_EXTLEN) && w_hdr_last) ||
                ((r_phase == PH_MASK) && w_hdr_last);

        case (r_phase)
            PH_SIZE:   w_chk_masked = i_byte[7];
            PH_EXTLEN: w_chk_masked = r_masked;
            default:   w_chk_masked = 1'b0;
        endcase

        case (r_phase)
            PH_SIZE:    w_new_len = w_ext ? 64'd0 : {57'd0, w_len7};
            PH_EXTLEN:  w_new_len = {r_len[55:0], i_byte};
            PH_PAYLOAD: w_new_len = r_len - 64'd1;
            default:    w_new_len = r_len;
        endcase

        w_to_mask = w_chk && w_chk_masked;
        w_to_pay  = w_chk && !w_chk_masked && (w_new_len != 64'd0);
        w_end     = (w_chk && !w_chk_masked && (w_new_len == 64'd0)) ||
                    ((r_phase == PH_PAYLOAD) && (w_new_len == 64'd0));
        w_done    = w_end && r_final && known_opcode(r_opcode);
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            case (r_phase)
                PH_OPCODE: n_phase = PH_SIZE;
                PH_SIZE, PH_EXTLEN, PH_MASK: begin
                    if ((r_phase == PH_SIZE) && w_ext) begin
                        n_phase = PH_EXTLEN;
                    end else if (w_to_mask) begin
                        n_phase = PH_MASK;
                    end else if (w_to_pay) begin
                        n_phase = PH_PAYLOAD;
                    end else if (w_end) begin
                        n_phase = PH_OPCODE;
                    end
                end
                PH_PAYLOAD: n_phase = w_end ? PH_OPCODE : PH_PAYLOAD;
                default:    n_phase = PH_OPCODE;
            endcase
        end
    end

    // Next value of the data state and the result item
    always_comb begin
        n_final    = r_final;
        n_opcode   = r_opcode;
        n_masked   = r_masked;
        n_len      = r_len;
        n_hdr      = r_hdr;
        n_key      = r_key;
        n_mask_idx = r_mask_idx;
        n_cnt      = r_cnt;
        n_ftb      = r_ftb;
        n_start    = r_start;

        if (i_valid) begin
            case (r_phase)
                PH_OPCODE: begin
                    n_final = i_byte[7];
                    if (i_byte[3:0] != OPC_CONT) begin
                        n_opcode = i_byte[3:0];
                        n_cnt    = 2'd0;
                        n_ftb    = 16'd0;
                        n_start  = 1'b1;
                    end
                    n_key      = '{default: 8'd0};
                    n_mask_idx = 2'd0;
                end
                PH_SIZE: begin
                    n_masked = i_byte[7];
                    n_len    = w_new_len;
                    if (w_len7 == LEN_EXT16) begin
                        n_hdr = HDR_EXT16;
                    end else if (w_len7 == LEN_EXT64) begin
                        n_hdr = HDR_EXT64;
                    end else if (w_to_mask) begin
                        n_hdr = HDR_MASK;
                    end
                end
                PH_EXTLEN: begin
                    n_len = w_new_len;
                    n_hdr = w_to_mask ? HDR_MASK : w_hdr_dec;
                end
                PH_MASK: begin
                    n_key[w_key_idx] = i_byte;
                    n_hdr            = w_hdr_dec;
                    if (w_hdr_last) begin
                        n_masked = 1'b0;
                    end
                end
                PH_PAYLOAD: begin
                    n_len      = w_new_len;
                    n_mask_idx = r_mask_idx + 2'd1;
                    if (r_cnt == 2'd0) begin
                        n_ftb = {w_pb, 8'd0};
                    end else if (r_cnt == 2'd1) begin
                        n_ftb = {r_ftb[15:8], w_pb};
                    end
                    if (r_cnt < 2'd2) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end

        // Result item, formed from the updated message bytes
        o_res_valid          = i_valid && ((r_phase == PH_PAYLOAD) || w_done);
        o_res.payload_valid  = (r_phase == PH_PAYLOAD);
        o_res.payload_byte   = (r_phase == PH_PAYLOAD) ? w_pb : 8'd0;
        o_res.message_start  = r_start;
        o_res.frame_done     = w_done;
        o_res.frame_type     = w_done ? opcode_type(r_opcode) : TYPE_TEXT;
        o_res.close_code     = (w_done && (r_opcode == OPC_CLOSE) && (n_cnt == 2'd2))
                               ? n_ftb : 16'd0;
        if (o_res_valid) begin
            n_start = 1'b0;
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPCODE;
            r_final    <= 1'b0;
            r_opcode   <= OPC_CONT;
            r_masked   <= 1'b0;
            r_len      <= 64'd0;
            r_hdr      <= 4'd0;
            r_key      <= '{default: 8'd0};
            r_mask_idx <= 2'd0;
            r_cnt      <= 2'd0;
            r_ftb      <= 16'd0;
            r_start    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_final    <= n_final;
            r_opcode   <= n_opcode;
            r_masked   <= n_masked;
            r_len      <= n_len;
            r_hdr      <= n_hdr;
            r_key      <= n_key;
            r_mask_idx <= n_mask_idx;
            r_cnt      <= n_cnt;
            r_ftb      <= n_ftb;
            r_start    <= n_start;
        end
    end

`ifndef NO_ASSERTIONS
    // The payload phase is only ever held with bytes still to come
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_len != 64'd0))
        else $error("payload phase with zero remaining length");

    // The mask key count stays between one and four while collecting it
    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MASK) |-> ((r_hdr != 4'd0) && (r_hdr <= HDR_MASK)))
        else $error("mask key byte count out of range");

    // The extended length count stays between one and eight while collecting it
    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXTLEN) |-> ((r_hdr != 4'd0) && (r_hdr <= HDR_EXT64)))
        else $error("extended length byte count out of range");
`endif

endmodule

// ===== rtl/wsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// wsd_out_buf
// Two-entry result buffer: holds result items until the output transfer, so
// that the parser keeps taking bytes while one result waits.
// ----------------------------------------------------------------------------
module wsd_out_buf
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_wsd_result i_res,
    output logic        o_not_full,
    output logic        o_valid,
    input  logic        i_ready,
    output t_wsd_result o_res
);

    t_wsd_result r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count,  n_count;
    logic        w_pop;

    // Pointer and occupancy control
    always_comb begin
        w_pop      = o_valid && i_ready;
        n_wr_ptr   = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr   = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count    = r_count + {1'b0, i_push} - {1'b0, w_pop};
        o_not_full = (r_count != 2'd2);
        o_valid    = (r_count != 2'd0);
        o_res      = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_not_full || w_pop))
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("result buffer count missed a push");
`endif

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle on the slave stream while the output
// buffer has room, and parses frame headers, extended lengths and mask keys in a
// single pass; each payload byte is unmasked and written into the output buffer
// as a result item, and a completed final frame of known opcode is reported with
// its type and, for close frames, the close code. Every byte is handled in the
// cycle it is taken, so the rate is one byte per clock, set by the per-byte
// parser step. A two-entry output buffer lets bytes keep flowing while a result
// waits; the input stalls only when both entries are held by a stalled consumer.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [7:0] payload_byte, [23:8] close_code
    output logic        o_m_axis_tlast,  // frame_done
    output logic [4:0]  o_m_axis_tuser   // [0] payload_valid, [1] message_start,
                                         // [4:2] frame_type
);

    logic        w_accept;
    logic        w_res_valid;
    t_wsd_result w_res;
    logic        w_not_full;
    t_wsd_result w_out;

    // A byte transfer completes when the buffer has room
    assign o_s_axis_tready = w_not_full;
    assign w_accept        = i_s_axis_tvalid && w_not_full;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_res_valid),
        .i_res      (w_res),
        .o_not_full (w_not_full),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (w_out)
    );

    // Pack the result item onto the output stream
    assign o_m_axis_tdata = {w_out.close_code, w_out.payload_byte};
    assign o_m_axis_tlast = w_out.frame_done;
    assign o_m_axis_tuser = {w_out.frame_type, w_out.message_start, w_out.payload_valid};

endmodule
